// File: hdl/time_of_day_seconds_arithmetic_unit_defines.svh
// Assertion macros shared by the time-of-day unit's modules.
`ifndef TIME_OF_DAY_SECONDS_ARITHMETIC_UNIT_DEFINES_SVH
`define TIME_OF_DAY_SECONDS_ARITHMETIC_UNIT_DEFINES_SVH

// A property that must hold at every edge outside reset.
`define TDSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold at every edge where the antecedent holds.
`define TDSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/tdsa_pkg.sv
// Shared constants, request codes and types of the time-of-day unit.
package tdsa_pkg;

  localparam int unsigned SEC_W = 17;

  localparam logic [SEC_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [SEC_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [5:0]       SECS_PER_MIN  = 6'd60;
  localparam logic [4:0]       HOURS_PER_DAY = 5'd24;

  localparam logic [1:0] REQ_SET = 2'd0;
  localparam logic [1:0] REQ_ADD = 2'd1;
  localparam logic [1:0] REQ_SUB = 2'd2;
  localparam logic [1:0] REQ_CMP = 2'd3;

  // Reciprocal of one day, scaled by 2^48; the quotient estimate is low by at most one.
  localparam int unsigned   DAY_SHIFT = 48;
  localparam logic [31:0]   RECIP_DAY = 32'((64'd1 << DAY_SHIFT) / 64'd86400);
  localparam int unsigned   QDAY_W    = 16;

  // Rounded-up reciprocals; exact for every value below one day or one hour.
  localparam int unsigned HOUR_SHIFT = 27;
  localparam logic [15:0] RECIP_HOUR = 16'(((32'd1 << HOUR_SHIFT) + 32'd3599) / 32'd3600);
  localparam int unsigned MIN_SHIFT  = 21;
  localparam logic [15:0] RECIP_MIN  = 16'(((32'd1 << MIN_SHIFT) + 32'd59) / 32'd60);

  typedef struct packed {
    logic [SEC_W-1:0] elapsed;
    logic             is_equal;
    logic             is_before;
    logic             is_after;
  } tdsa_cmp_t;

endpackage

// File: hdl/time_of_day_seconds_arithmetic_unit.sv
// Top level of the time-of-day unit: request decode, day reduction and stored time.
//
// Holds a time of day and serves one request item per cycle on the in_ channel:
// set, add seconds, subtract seconds, or compare against a given time. Each
// accepted item yields exactly one result item on the out_ channel carrying the
// stored time after the request plus, for compare, the elapsed seconds and the
// equal, before and after flags. Both channels use valid and stall; an item moves
// on an edge where valid is high and stall is low.
// An accepted item moves through stages s1, s2 and s3, then a, b, c and o in tdsa_split.
// Throughput is one item per cycle; every stage has its own valid bit and
// moves whenever the stage after it is empty or moving, so bubbles close up.
// The stored time is kept as seconds since midnight and updated in the third
// stage, so back-to-back requests each see the effect of the one before.
// The amount is reduced modulo one day by a reciprocal multiply and a
// correction over the first two stages; the last four split seconds into
// hour, minute and second.
// Reset clears the stored time to midnight and empties the pipeline.
// A stall on out_ holds the result; the pipeline keeps accepting items until
// every stage is full, then raises in_stall.
`include "time_of_day_seconds_arithmetic_unit_defines.svh"

module time_of_day_seconds_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [4:0]  in_time_hour,
  input  logic [5:0]  in_time_minute,
  input  logic [5:0]  in_time_second,
  input  logic [31:0] in_amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [16:0] out_elapsed_seconds,
  output logic        out_is_equal,
  output logic        out_is_before,
  output logic        out_is_after
);

  logic                         s1_v_r, s2_v_r, s3_v_r;
  logic                         s1_rdy, s2_rdy, s3_rdy, split_rdy;

  logic [1:0]                   s1_req_r, s2_req_r;
  logic [tdsa_pkg::SEC_W-1:0]   s1_given_r, s2_given_r;
  logic [31:0]                  s1_amount_r;
  logic [tdsa_pkg::QDAY_W-1:0]  s1_q_r;
  logic [tdsa_pkg::SEC_W-1:0]   s2_delta_r;
  logic [tdsa_pkg::SEC_W-1:0]   cur_r, s3_t_r;
  tdsa_pkg::tdsa_cmp_t          s3_cmp_r;

  logic [4:0]                   gh;
  logic [5:0]                   gm, gs;
  logic [tdsa_pkg::SEC_W-1:0]   given_nxt;
  logic [63:0]                  day_prod;
  logic [31:0]                  q_base;
  logic [31:0]                  rem_raw;
  logic [17:0]                  rem_lo;
  logic [tdsa_pkg::SEC_W-1:0]   delta_nxt;
  logic [17:0]                  add_sum;
  logic [tdsa_pkg::SEC_W-1:0]   add_t, sub_t, elapsed_t, t_nxt;
  tdsa_pkg::tdsa_cmp_t          cmp_nxt;

  assign s3_rdy   = !s3_v_r || split_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = !s1_rdy;

  // Out-of-range parts of a given time count as zero.
  assign gh = (in_time_hour   < tdsa_pkg::HOURS_PER_DAY) ? in_time_hour   : 5'd0;
  assign gm = (in_time_minute < tdsa_pkg::SECS_PER_MIN)  ? in_time_minute : 6'd0;
  assign gs = (in_time_second < tdsa_pkg::SECS_PER_MIN)  ? in_time_second : 6'd0;
  assign given_nxt = 17'(gh) * tdsa_pkg::SECS_PER_HOUR
                   + 17'(gm) * 17'(tdsa_pkg::SECS_PER_MIN) + 17'(gs);

  assign day_prod = 64'(in_amount) * 64'(tdsa_pkg::RECIP_DAY);

  // The quotient may be one short, leaving a remainder below two days.
  assign q_base    = 32'(s1_q_r) * 32'(tdsa_pkg::SECS_PER_DAY);
  assign rem_raw   = s1_amount_r - q_base;
  assign rem_lo    = rem_raw[17:0];
  assign delta_nxt = (rem_lo >= 18'(tdsa_pkg::SECS_PER_DAY))
                   ? 17'(rem_lo - 18'(tdsa_pkg::SECS_PER_DAY)) : rem_lo[16:0];

  assign add_sum   = 18'(cur_r) + 18'(s2_delta_r);
  assign add_t     = (add_sum >= 18'(tdsa_pkg::SECS_PER_DAY))
                   ? 17'(add_sum - 18'(tdsa_pkg::SECS_PER_DAY)) : add_sum[16:0];
  assign sub_t     = (cur_r >= s2_delta_r) ? cur_r - s2_delta_r
                   : cur_r + (tdsa_pkg::SECS_PER_DAY - s2_delta_r);
  assign elapsed_t = (cur_r >= s2_given_r) ? cur_r - s2_given_r
                   : cur_r + (tdsa_pkg::SECS_PER_DAY - s2_given_r);

  always_comb begin
    cmp_nxt = '0;
    t_nxt   = cur_r;
    case (s2_req_r)
      tdsa_pkg::REQ_SET: t_nxt = s2_given_r;
      tdsa_pkg::REQ_ADD: t_nxt = add_t;
      tdsa_pkg::REQ_SUB: t_nxt = sub_t;
      tdsa_pkg::REQ_CMP: begin
        cmp_nxt.elapsed   = elapsed_t;
        cmp_nxt.is_equal  = (cur_r == s2_given_r);
        cmp_nxt.is_before = (cur_r <  s2_given_r);
        cmp_nxt.is_after  = (cur_r >  s2_given_r);
      end
      default: t_nxt = cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      cur_r  <= '0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (s3_rdy && s2_v_r) cur_r <= t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_req_r    <= in_req_type;
      s1_given_r  <= given_nxt;
      s1_amount_r <= in_amount;
      s1_q_r      <= day_prod[tdsa_pkg::DAY_SHIFT +: tdsa_pkg::QDAY_W];
    end
    if (s2_rdy && s1_v_r) begin
      s2_req_r   <= s1_req_r;
      s2_given_r <= s1_given_r;
      s2_delta_r <= delta_nxt;
    end
    if (s3_rdy && s2_v_r) begin
      s3_t_r   <= t_nxt;
      s3_cmp_r <= cmp_nxt;
    end
  end

  tdsa_split u_split (
    .clk                 (clk),
    .rst_n               (rst_n),
    .up_valid            (s3_v_r),
    .up_ready            (split_rdy),
    .up_secs             (s3_t_r),
    .up_cmp              (s3_cmp_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hour            (out_hour),
    .out_minute          (out_minute),
    .out_second          (out_second),
    .out_elapsed_seconds (out_elapsed_seconds),
    .out_is_equal        (out_is_equal),
    .out_is_before       (out_is_before),
    .out_is_after        (out_is_after)
  );

  `TDSA_ASSERT(a_state_in_day, cur_r < tdsa_pkg::SECS_PER_DAY, "stored time beyond one day")
  `TDSA_ASSERT_IMPL(a_delta_in_day, s2_v_r, s2_delta_r < tdsa_pkg::SECS_PER_DAY, "bad day remainder")
  `TDSA_ASSERT_IMPL(a_state_match, s3_v_r, s3_t_r == cur_r, "stage three disagrees with stored time")
  `TDSA_ASSERT_IMPL(a_flags_onehot0, s3_v_r, ($onehot0({s3_cmp_r.is_equal, s3_cmp_r.is_before, s3_cmp_r.is_after})), "conflicting compare flags")
  `TDSA_ASSERT_IMPL(a_equal_zero, s3_v_r && s3_cmp_r.is_equal, s3_cmp_r.elapsed == 17'd0, "equal times with nonzero elapsed")

endmodule

// File: hdl/tdsa_split.sv
// Pipeline that splits seconds since midnight into hour, minute and second.
`include "time_of_day_seconds_arithmetic_unit_defines.svh"

module tdsa_split (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [tdsa_pkg::SEC_W-1:0] up_secs,
  input  tdsa_pkg::tdsa_cmp_t        up_cmp,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [4:0]                 out_hour,
  output logic [5:0]                 out_minute,
  output logic [5:0]                 out_second,
  output logic [16:0]                out_elapsed_seconds,
  output logic                       out_is_equal,
  output logic                       out_is_before,
  output logic                       out_is_after
);

  logic                       a_v_r, b_v_r, c_v_r, o_v_r;
  logic                       a_rdy, b_rdy, c_rdy, o_rdy;

  logic [tdsa_pkg::SEC_W-1:0] a_t_r;
  logic [4:0]                 a_h_r, b_h_r, c_h_r, o_h_r;
  logic [11:0]                b_rem_r, c_rem_r;
  logic [5:0]                 c_m_r, o_m_r, o_s_r;
  tdsa_pkg::tdsa_cmp_t        a_cmp_r, b_cmp_r, c_cmp_r, o_cmp_r;

  logic [32:0]                hour_prod;
  logic [4:0]                 a_h_nxt;
  logic [tdsa_pkg::SEC_W-1:0] hour_base;
  logic [tdsa_pkg::SEC_W-1:0] rem_full;
  logic [11:0]                b_rem_nxt;
  logic [27:0]                min_prod;
  logic [5:0]                 c_m_nxt;
  logic [11:0]                min_base;
  logic [11:0]                sec_full;
  logic [5:0]                 o_s_nxt;

  assign o_rdy    = !o_v_r || !out_stall;
  assign c_rdy    = !c_v_r || o_rdy;
  assign b_rdy    = !b_v_r || c_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign up_ready = a_rdy;

  assign hour_prod = 33'(up_secs) * 33'(tdsa_pkg::RECIP_HOUR);
  assign a_h_nxt   = hour_prod[tdsa_pkg::HOUR_SHIFT +: 5];

  assign hour_base = 17'(a_h_r) * tdsa_pkg::SECS_PER_HOUR;
  assign rem_full  = a_t_r - hour_base;
  assign b_rem_nxt = rem_full[11:0];

  assign min_prod  = 28'(b_rem_r) * 28'(tdsa_pkg::RECIP_MIN);
  assign c_m_nxt   = min_prod[tdsa_pkg::MIN_SHIFT +: 6];

  assign min_base  = 12'(c_m_r) * 12'(tdsa_pkg::SECS_PER_MIN);
  assign sec_full  = c_rem_r - min_base;
  assign o_s_nxt   = sec_full[5:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= up_valid;
      if (b_rdy) b_v_r <= a_v_r;
      if (c_rdy) c_v_r <= b_v_r;
      if (o_rdy) o_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && up_valid) begin
      a_t_r   <= up_secs;
      a_h_r   <= a_h_nxt;
      a_cmp_r <= up_cmp;
    end
    if (b_rdy && a_v_r) begin
      b_rem_r <= b_rem_nxt;
      b_h_r   <= a_h_r;
      b_cmp_r <= a_cmp_r;
    end
    if (c_rdy && b_v_r) begin
      c_m_r   <= c_m_nxt;
      c_rem_r <= b_rem_r;
      c_h_r   <= b_h_r;
      c_cmp_r <= b_cmp_r;
    end
    if (o_rdy && c_v_r) begin
      o_s_r   <= o_s_nxt;
      o_m_r   <= c_m_r;
      o_h_r   <= c_h_r;
      o_cmp_r <= c_cmp_r;
    end
  end

  assign out_valid           = o_v_r;
  assign out_hour            = o_h_r;
  assign out_minute          = o_m_r;
  assign out_second          = o_s_r;
  assign out_elapsed_seconds = o_cmp_r.elapsed;
  assign out_is_equal        = o_cmp_r.is_equal;
  assign out_is_before       = o_cmp_r.is_before;
  assign out_is_after        = o_cmp_r.is_after;

  `TDSA_ASSERT_IMPL(a_hour_range, o_v_r, o_h_r < tdsa_pkg::HOURS_PER_DAY, "hour out of range")
  `TDSA_ASSERT_IMPL(a_min_range, o_v_r, o_m_r < tdsa_pkg::SECS_PER_MIN, "minute out of range")
  `TDSA_ASSERT_IMPL(a_rem_range, c_v_r, c_rem_r < 12'd3600, "hour remainder out of range")

endmodule
